[hdl/afq_pkg.sv]
// ----------------------------------------------------------------------------
// afq_pkg
// Shared types and codes of the affinity ready queue: operation codes,
// status codes and the command bundle for the per-task flag store.
// ----------------------------------------------------------------------------
`default_nettype none

package afq_pkg;

  // Operation carried by one input transaction
  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_PICK    = 2'd1,
    OP_KILL    = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  // Status codes reported with each result
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Update strobes for the per-task flag store
  typedef struct packed {
    logic set_kill;       // mark task at the command index killed
    logic clear_kill;     // clear the kill mark at the command index
    logic mark_queued;    // task at the command index enters the queue
    logic unmark_queued;  // task at the probe index leaves the queue
  } flag_cmd_t;

endpackage

`default_nettype wire

[hdl/afq_task_flags.sv]
// ----------------------------------------------------------------------------
// afq_task_flags
// Per-task kill marks and queued flags, one flip-flop per task, cleared by
// reset. The queued flag stands for "task id is present in the queue".
// ----------------------------------------------------------------------------
`default_nettype none

module afq_task_flags #(
  parameter int MAX_TASKS = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire afq_pkg::flag_cmd_t       cmd,
  input  wire [$clog2(MAX_TASKS)-1:0]   cmd_idx,
  input  wire [$clog2(MAX_TASKS)-1:0]   probe_idx,
  output logic                          cmd_queued,
  output logic                          probe_killed
);

  logic [MAX_TASKS-1:0] kill_marks;
  logic [MAX_TASKS-1:0] queued;

  // Look up the flags of the addressed tasks
  assign cmd_queued   = queued[cmd_idx];
  assign probe_killed = kill_marks[probe_idx];

  // Update kill marks and queued flags
  always_ff @(posedge clk) begin
    if (rst) begin
      kill_marks <= '0;
      queued     <= '0;
    end else begin
      if (cmd.set_kill) begin
        kill_marks[cmd_idx] <= 1'b1;
      end else if (cmd.clear_kill) begin
        kill_marks[cmd_idx] <= 1'b0;
      end
      if (cmd.mark_queued) begin
        queued[cmd_idx] <= 1'b1;
      end
      if (cmd.unmark_queued) begin
        queued[probe_idx] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/affinity_ready_queue.sv]
// ----------------------------------------------------------------------------
// affinity_ready_queue
// Ready queue of a multi-core scheduler: FIFO of task ids in a synchronous
// memory, per-task affinity masks in a second memory, kill marks and queued
// flags in flip-flops. Pick scans the queue for the first eligible task and
// closes the gap behind it; remove scans for its task and does the same.
// ----------------------------------------------------------------------------
// Enqueue, kill and a remove of an absent task give their result in the cycle
//   after start; the next transaction may start in that same cycle.
// Pick and remove scan one queue entry per cycle through the order memory
//   port, then shift the tail down one entry per cycle.
// Throughput: one transaction at a time while busy is high.
// Reset (synchronous): empties the queue and clears all kill marks; memory
//   contents are kept; the order memory is never read before being written.
`default_nettype none

module affinity_ready_queue #(
  parameter int MAX_TASKS = 16,
  parameter int NUM_CPUS  = 2
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire  [1:0] operation,
  input  wire  [3:0] task_id,
  input  wire  [1:0] affinity_mask,
  input  wire        cpu_index,
  input  wire        requeue_first,
  output logic       done,
  output logic [3:0] granted_task,
  output logic       idle,
  output logic [1:0] status
);

  localparam int TW    = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DROP
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  afq_pkg::op_t        op_r;
  logic [TW-1:0]       t_r;
  logic [CPU_W-1:0]    cpu_r;
  logic [1:0]          status_r;
  logic [TW-1:0]       grant_r;

  // scan pipeline: address, order data, affinity data
  logic [CNT_W-1:0]    scan_addr;
  logic                v1;
  logic [TW-1:0]       pos1;
  logic                v2;
  logic [TW-1:0]       pos2;
  logic [TW-1:0]       id2;

  // gap closing
  logic [CNT_W-1:0]    drop_rd;
  logic                wv;
  logic [TW-1:0]       wa;

  // memories
  logic [TW-1:0]       order_mem [MAX_TASKS];
  logic [NUM_CPUS-1:0] aff_mem [MAX_TASKS];
  logic                q_we;
  logic [TW-1:0]       q_waddr;
  logic [TW-1:0]       q_wdata;
  logic                q_re;
  logic [TW-1:0]       q_raddr;
  logic [TW-1:0]       q_rdata;
  logic                aff_we;
  logic [NUM_CPUS-1:0] aff_wdata;
  logic                aff_re;
  logic [NUM_CPUS-1:0] aff_rdata;

  // input decode
  afq_pkg::op_t        op_in;
  logic [TW-1:0]       t_in;
  logic [8:0]          t_mod;
  logic [7:0]          mask_wide;
  logic                full;
  logic                cmd_queued;
  logic                probe_killed;
  logic                append;
  logic                cpu_ok;
  logic                match;
  logic                found;
  afq_pkg::flag_cmd_t  flag_cmd;

  assign op_in     = afq_pkg::op_t'(operation);
  assign mask_wide = 8'(affinity_mask);
  assign aff_wdata = mask_wide[NUM_CPUS-1:0];
  assign full      = (count == CNT_W'(MAX_TASKS));
  assign busy      = (state != S_IDLE);

  // Reduce the task id modulo the table depth by repeated subtraction
  always_comb begin
    t_mod = 9'(task_id);
    for (int k = 0; k < 8; k++) begin
      if (t_mod >= 9'(MAX_TASKS)) begin
        t_mod = t_mod - 9'(MAX_TASKS);
      end
    end
    t_in = t_mod[TW-1:0];
  end

  // Append happens on enqueue, or on a pick that requeues, when absent and room
  assign append = !busy && start && !cmd_queued && !full &&
                  ((op_in == afq_pkg::OP_ENQUEUE) ||
                   ((op_in == afq_pkg::OP_PICK) && requeue_first));

  // Eligibility of the entry at the end of the scan pipeline
  assign cpu_ok = ({1'b0, cpu_r} < (CPU_W + 1)'(NUM_CPUS));
  assign match  = (op_r == afq_pkg::OP_REMOVE) ? (id2 == t_r)
                                               : (cpu_ok && aff_rdata[cpu_r] && !probe_killed);
  assign found  = (state == S_SCAN) && v2 && match;

  // Drive memory ports and flag updates
  always_comb begin
    q_we      = 1'b0;
    q_waddr   = count[TW-1:0];
    q_wdata   = t_in;
    q_re      = 1'b0;
    q_raddr   = scan_addr[TW-1:0];
    aff_we    = 1'b0;
    aff_re    = 1'b0;
    flag_cmd  = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          q_we                 = append;
          flag_cmd.mark_queued = append;
          aff_we               = (op_in == afq_pkg::OP_ENQUEUE);
          flag_cmd.set_kill    = (op_in == afq_pkg::OP_KILL);
          flag_cmd.clear_kill  = (op_in == afq_pkg::OP_REMOVE);
        end
      end
      S_SCAN: begin
        q_re                   = (scan_addr < count) && !found;
        aff_re                 = v1;
        flag_cmd.unmark_queued = found;
      end
      S_DROP: begin
        q_re    = (drop_rd < count);
        q_raddr = drop_rd[TW-1:0];
        q_we    = wv;
        q_waddr = wa;
        q_wdata = q_rdata;
      end
      default: begin
      end
    endcase
  end

  // Task order memory
  always_ff @(posedge clk) begin
    if (q_we) begin
      order_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata <= order_mem[q_raddr];
    end
  end

  // Affinity mask memory, read with the id that the order memory returns
  always_ff @(posedge clk) begin
    if (aff_we) begin
      aff_mem[t_in] <= aff_wdata;
    end
    if (aff_re) begin
      aff_rdata <= aff_mem[q_rdata];
    end
  end

  afq_task_flags #(
    .MAX_TASKS (MAX_TASKS)
  ) u_flags (
    .clk          (clk),
    .rst          (rst),
    .cmd          (flag_cmd),
    .cmd_idx      (t_in),
    .probe_idx    (id2),
    .cmd_queued   (cmd_queued),
    .probe_killed (probe_killed)
  );

  // Sequencer: accept, scan, close the gap, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      wv    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r         <= op_in;
            t_r          <= t_in;
            cpu_r        <= CPU_W'(cpu_index);
            scan_addr    <= '0;
            v1           <= 1'b0;
            v2           <= 1'b0;
            granted_task <= 4'd0;
            idle         <= 1'b0;
            if (append) begin
              count <= count + CNT_W'(1);
            end
            case (op_in)
              afq_pkg::OP_ENQUEUE: begin
                done   <= 1'b1;
                status <= (!cmd_queued && full) ? afq_pkg::ST_FULL : afq_pkg::ST_OK;
              end
              afq_pkg::OP_PICK: begin
                status_r <= (requeue_first && !cmd_queued && full) ? afq_pkg::ST_FULL
                                                                    : afq_pkg::ST_OK;
                if ((count == '0) && !append) begin
                  done   <= 1'b1;
                  idle   <= 1'b1;
                  status <= afq_pkg::ST_OK;
                end else begin
                  state <= S_SCAN;
                end
              end
              afq_pkg::OP_KILL: begin
                done   <= 1'b1;
                status <= afq_pkg::ST_OK;
              end
              afq_pkg::OP_REMOVE: begin
                status_r <= afq_pkg::ST_OK;
                if (cmd_queued) begin
                  state <= S_SCAN;
                end else begin
                  done   <= 1'b1;
                  status <= afq_pkg::ST_NOT_FOUND;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // advance the scan pipeline
          if (q_re) begin
            scan_addr <= scan_addr + CNT_W'(1);
          end
          v1   <= q_re;
          pos1 <= scan_addr[TW-1:0];
          v2   <= v1;
          pos2 <= pos1;
          id2  <= q_rdata;
          if (found) begin
            state   <= S_DROP;
            drop_rd <= CNT_W'(pos2) + CNT_W'(1);
            v1      <= 1'b0;
            v2      <= 1'b0;
            wv      <= 1'b0;
            grant_r <= id2;
          end else if (!v1 && !v2 && !q_re) begin
            // nothing eligible in the whole queue
            state        <= S_IDLE;
            done         <= 1'b1;
            idle         <= 1'b1;
            granted_task <= 4'd0;
            status       <= status_r;
          end
        end
        S_DROP: begin
          // shift the tail down by one entry
          if (q_re) begin
            drop_rd <= drop_rd + CNT_W'(1);
            wa      <= TW'(drop_rd - CNT_W'(1));
          end
          wv <= q_re;
          if (!q_re && !wv) begin
            state        <= S_IDLE;
            count        <= count - CNT_W'(1);
            done         <= 1'b1;
            idle         <= 1'b0;
            status       <= status_r;
            granted_task <= (op_r == afq_pkg::OP_PICK) ? 4'(grant_r) : 4'd0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/afq_checker.sv]
// ----------------------------------------------------------------------------
// afq_checker
// Port-level checks of the affinity ready queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module afq_checker (
  input wire       clk,
  input wire       rst,
  input wire       start,
  input wire       busy,
  input wire [1:0] operation,
  input wire       done,
  input wire [3:0] granted_task,
  input wire       idle,
  input wire [1:0] status
);

  // Results appear only once the block has gone back to accepting
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Enqueue and kill finish in the cycle after they are accepted
  a_short_ops: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ((operation == afq_pkg::OP_ENQUEUE) ||
                        (operation == afq_pkg::OP_KILL))) |=> (done && !busy))
    else $error("enqueue or kill did not complete in one cycle");

  // An idle answer grants no task
  a_idle_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && idle) |-> (granted_task == 4'd0))
    else $error("idle result carries a task");

  // Busy rises only after an accepted transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // Only defined status codes are reported
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == afq_pkg::ST_OK) || (status == afq_pkg::ST_FULL) ||
              (status == afq_pkg::ST_NOT_FOUND)))
    else $error("undefined status code");

endmodule

bind affinity_ready_queue afq_checker u_afq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .operation    (operation),
  .done         (done),
  .granted_task (granted_task),
  .idle         (idle),
  .status       (status)
);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the affinity ready queue. A local scheduler model
// tracks queue order, per-task masks and kill marks, predicts the grant,
// idle flag and status of every transaction, and a monitor compares each
// done strobe against the oldest prediction. Directed tests cover enqueue,
// pick, requeue, kill and remove corner cases; a long random phase follows.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TASKS        = 16;
  localparam int RANDOM_ITEMS = 1225;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [3:0] granted;
    logic       idle;
    logic [1:0] status;
  } grant_t;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  afq_pkg::op_t operation;
  logic [3:0]   task_id;
  logic [1:0]   affinity_mask;
  logic         cpu_index;
  logic         requeue_first;
  logic         done;
  logic [3:0]   granted_task;
  logic         idle;
  logic [1:0]   status;

  // Scheduler model state
  logic [3:0] ready_order [TASKS];
  int         ready_count;
  logic [1:0] task_mask [TASKS];
  logic       task_killed [TASKS];
  logic       mask_written [TASKS];

  grant_t pending_grants [$];
  int     mismatches = 0;
  int     cycles = 0;
  int     max_gap = 6;

  affinity_ready_queue DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .task_id       (task_id),
    .affinity_mask (affinity_mask),
    .cpu_index     (cpu_index),
    .requeue_first (requeue_first),
    .done          (done),
    .granted_task  (granted_task),
    .idle          (idle),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Position of a task in the queue, or ready_count when absent
  function automatic int find_task(input logic [3:0] t);
    int i;
    int pos;
    pos = ready_count;
    for (i = ready_count - 1; i >= 0; i--) begin
      if (ready_order[i] == t) pos = i;
    end
    return pos;
  endfunction

  // Close the gap left by the entry at pos
  function automatic void drop_entry(input int pos);
    int i;
    for (i = pos; i + 1 < ready_count; i++) ready_order[i] = ready_order[i + 1];
    ready_count--;
  endfunction

  function automatic logic [1:0] append_task(input logic [3:0] t);
    if (find_task(t) < ready_count) return afq_pkg::ST_OK;
    if (ready_count >= TASKS) return afq_pkg::ST_FULL;
    ready_order[ready_count] = t;
    ready_count++;
    return afq_pkg::ST_OK;
  endfunction

  // Advance the model by one transaction and return its expected result
  function automatic grant_t predict_grant(input afq_pkg::op_t op, input logic [3:0] t,
                                           input logic [1:0] mask, input logic cpu,
                                           input logic requeue);
    grant_t r;
    int     i;
    int     pos;
    r   = '0;
    pos = 0;
    case (op)
      afq_pkg::OP_ENQUEUE: begin
        task_mask[t] = mask;
        r.status = append_task(t);
      end
      afq_pkg::OP_PICK: begin
        if (requeue) r.status = append_task(t);
        r.idle = 1'b1;
        // Take the first allowed task that is not killed
        for (i = 0; i < ready_count; i++) begin
          if (r.idle && task_mask[ready_order[i]][cpu] && !task_killed[ready_order[i]]) begin
            r.granted = ready_order[i];
            r.idle    = 1'b0;
            pos       = i;
          end
        end
        if (!r.idle) drop_entry(pos);
      end
      afq_pkg::OP_KILL: begin
        task_killed[t] = 1'b1;
      end
      default: begin
        task_killed[t] = 1'b0;
        pos = find_task(t);
        if (pos < ready_count) drop_entry(pos);
        else r.status = afq_pkg::ST_NOT_FOUND;
      end
    endcase
    return r;
  endfunction

  // Present one transaction after a random gap and wait for its acceptance
  task automatic send_item(input afq_pkg::op_t op, input logic [3:0] t,
                           input logic [1:0] mask, input logic cpu, input logic requeue);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    operation     <= op;
    task_id       <= t;
    affinity_mask <= mask;
    cpu_index     <= cpu;
    requeue_first <= requeue;
    do @(posedge clk); while (busy);
    if (op == afq_pkg::OP_ENQUEUE) mask_written[t] = 1'b1;
    pending_grants.push_back(predict_grant(op, t, mask, cpu, requeue));
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    grant_t want;
    if (!rst && done) begin
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result granted=%0d idle=%0b status=%0d",
                                  granted_task, idle, status));
      end else begin
        want = pending_grants.pop_front();
        if (granted_task !== want.granted)
          report_mismatch($sformatf("granted_task %0d, expected %0d",
                                    granted_task, want.granted));
        if (idle !== want.idle)
          report_mismatch($sformatf("idle %0b, expected %0b", idle, want.idle));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      end
    end
  end

  task automatic test_enqueue_and_pick;
    send_item(afq_pkg::OP_ENQUEUE, 4'd0, 2'b01, 1'b0, 1'b0);
    send_item(afq_pkg::OP_ENQUEUE, 4'd15, 2'b10, 1'b1, 1'b0);
    send_item(afq_pkg::OP_ENQUEUE, 4'd5, 2'b11, 1'b0, 1'b0);
    send_item(afq_pkg::OP_ENQUEUE, 4'd7, 2'b00, 1'b1, 1'b0);
    // Already queued: mask changes, place is kept
    send_item(afq_pkg::OP_ENQUEUE, 4'd0, 2'b11, 1'b0, 1'b0);
    send_item(afq_pkg::OP_PICK, 4'd9, 2'b00, 1'b1, 1'b0);
    send_item(afq_pkg::OP_PICK, 4'd3, 2'b11, 1'b1, 1'b0);
    // Yielding task goes to the tail before the scan
    send_item(afq_pkg::OP_PICK, 4'd15, 2'b00, 1'b0, 1'b1);
  endtask

  task automatic test_kill_marks;
    send_item(afq_pkg::OP_KILL, 4'd15, 2'b11, 1'b1, 1'b0);
    send_item(afq_pkg::OP_PICK, 4'd0, 2'b00, 1'b1, 1'b0);
    // Enqueue keeps the kill mark
    send_item(afq_pkg::OP_ENQUEUE, 4'd15, 2'b11, 1'b0, 1'b0);
    send_item(afq_pkg::OP_PICK, 4'd0, 2'b00, 1'b0, 1'b0);
    send_item(afq_pkg::OP_KILL, 4'd3, 2'b00, 1'b0, 1'b1);
    send_item(afq_pkg::OP_ENQUEUE, 4'd3, 2'b01, 1'b1, 1'b1);
    send_item(afq_pkg::OP_PICK, 4'd0, 2'b00, 1'b0, 1'b0);
  endtask

  task automatic test_remove;
    send_item(afq_pkg::OP_REMOVE, 4'd15, 2'b00, 1'b0, 1'b0);
    send_item(afq_pkg::OP_REMOVE, 4'd15, 2'b11, 1'b1, 1'b1);
    send_item(afq_pkg::OP_REMOVE, 4'd3, 2'b00, 1'b0, 1'b0);
    send_item(afq_pkg::OP_REMOVE, 4'd7, 2'b00, 1'b0, 1'b0);
    send_item(afq_pkg::OP_PICK, 4'd0, 2'b00, 1'b0, 1'b0);
    send_item(afq_pkg::OP_ENQUEUE, 4'd2, 2'b10, 1'b0, 1'b0);
    // Requeue of a task that is already queued leaves the queue as is
    send_item(afq_pkg::OP_PICK, 4'd2, 2'b00, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic;
    int           n;
    int           k;
    int           mode;
    int           sel;
    afq_pkg::op_t op;
    logic [3:0]   t;
    logic         requeue;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      // Each burst leans toward filling, draining, mixing or killing
      mode    = $urandom_range(0, 3);
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
      for (k = 0; k < 40 && n < RANDOM_ITEMS; k++) begin
        sel = $urandom_range(0, 99);
        case (mode)
          0:       op = (sel < 60) ? afq_pkg::OP_ENQUEUE : (sel < 80) ? afq_pkg::OP_PICK :
                        (sel < 88) ? afq_pkg::OP_KILL : afq_pkg::OP_REMOVE;
          1:       op = (sel < 20) ? afq_pkg::OP_ENQUEUE : (sel < 85) ? afq_pkg::OP_PICK :
                        (sel < 90) ? afq_pkg::OP_KILL : afq_pkg::OP_REMOVE;
          2:       op = (sel < 35) ? afq_pkg::OP_ENQUEUE : (sel < 70) ? afq_pkg::OP_PICK :
                        (sel < 80) ? afq_pkg::OP_KILL : afq_pkg::OP_REMOVE;
          default: op = (sel < 25) ? afq_pkg::OP_ENQUEUE : (sel < 55) ? afq_pkg::OP_PICK :
                        (sel < 75) ? afq_pkg::OP_KILL : afq_pkg::OP_REMOVE;
        endcase
        t = 4'($urandom_range(0, 15));
        // Aim kills and removes mostly at queued tasks
        if ((op == afq_pkg::OP_KILL || op == afq_pkg::OP_REMOVE) && ready_count > 0 &&
            $urandom_range(0, 9) < 7)
          t = ready_order[$urandom_range(0, ready_count - 1)];
        requeue = 1'($urandom_range(0, 1));
        // Never requeue a task whose mask was never set
        if (op == afq_pkg::OP_PICK && requeue && !mask_written[t]) requeue = 1'b0;
        send_item(op, t, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), requeue);
        n++;
      end
    end
    max_gap = 6;
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    operation     = afq_pkg::OP_ENQUEUE;
    task_id       = '0;
    affinity_mask = '0;
    cpu_index     = 1'b0;
    requeue_first = 1'b0;
    ready_count   = 0;
    for (int i = 0; i < TASKS; i++) begin
      ready_order[i]  = '0;
      task_mask[i]    = '0;
      task_killed[i]  = 1'b0;
      mask_written[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_enqueue_and_pick();
    test_kill_marks();
    test_remove();
    test_random_traffic();
    start <= 1'b0;

    // Drain outstanding results, then hold for late strays
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/afq_pkg.sv
hdl/afq_task_flags.sv
hdl/affinity_ready_queue.sv
hdl/afq_checker.sv
tb/tb_top.sv
